[src/bcs_pkg.sv]
// Shared types and constants for the bounded character stack with sort.
// Used by bcs_front, bcs_back, the top level and the checker.
package bcs_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  // command queue depth between front and back, a power of two
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [7:0] EMPTY_MARK = 8'h23;  // '#'

  localparam logic [2:0] ACT_PUSH     = 3'd0;
  localparam logic [2:0] ACT_POP      = 3'd1;
  localparam logic [2:0] ACT_CLEAR    = 3'd2;
  localparam logic [2:0] ACT_CANCEL   = 3'd3;
  localparam logic [2:0] ACT_SORT     = 3'd4;
  localparam logic [2:0] ACT_REVERSE  = 3'd5;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_CLEAR,
    OP_CANCEL,
    OP_SORT,
    OP_REVERSE,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] push_char;
  } cmd_t;

  typedef struct packed {
    logic [7:0] popped_char;
    logic       pop_valid;
    logic [7:0] top_char;
    logic [4:0] fill_count;
    logic       is_empty;
    logic       is_full;
  } res_t;

  // decoded word held in the command queue
  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } qitem_t;

  // queue output toward the back end
  typedef struct packed {
    logic   valid;
    qitem_t item;
  } qhead_t;

endpackage

[src/bcs_front.sv]
// Front end: accepts command words, decodes the action, queues them.
// Depends on bcs_pkg.
module bcs_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  bcs_pkg::cmd_t   cmd,
  output bcs_pkg::qhead_t head,
  input  logic            take
);

  localparam int QAW = (bcs_pkg::QUEUE_DEPTH > 1) ? $clog2(bcs_pkg::QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(bcs_pkg::QUEUE_DEPTH + 1);

  bcs_pkg::qitem_t slots [bcs_pkg::QUEUE_DEPTH];
  logic [QAW-1:0]  wr_ptr;
  logic [QAW-1:0]  rd_ptr;
  logic [QCW-1:0]  used;

  logic            push_en;
  logic            pop_en;
  bcs_pkg::qitem_t decoded;

  always_comb begin
    decoded.ch = cmd.push_char;
    case (cmd.action)
      bcs_pkg::ACT_PUSH:    decoded.op = bcs_pkg::OP_PUSH;
      bcs_pkg::ACT_POP:     decoded.op = bcs_pkg::OP_POP;
      bcs_pkg::ACT_CLEAR:   decoded.op = bcs_pkg::OP_CLEAR;
      bcs_pkg::ACT_CANCEL:  decoded.op = bcs_pkg::OP_CANCEL;
      bcs_pkg::ACT_SORT:    decoded.op = bcs_pkg::OP_SORT;
      bcs_pkg::ACT_REVERSE: decoded.op = bcs_pkg::OP_REVERSE;
      default:              decoded.op = bcs_pkg::OP_NOP;
    endcase
  end

  assign cmd_ready  = (used != QCW'(bcs_pkg::QUEUE_DEPTH));
  assign push_en    = cmd_valid && cmd_ready;
  assign head.valid = (used != '0);
  assign head.item  = slots[rd_ptr];
  assign pop_en     = take && head.valid;

  always_ff @(posedge clk) begin
    if (push_en) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push_en) wr_ptr <= wr_ptr + QAW'(1);
      if (pop_en)  rd_ptr <= rd_ptr + QAW'(1);
      case ({push_en, pop_en})
        2'b10:   used <= used + QCW'(1);
        2'b01:   used <= used - QCW'(1);
        default: used <= used;
      endcase
    end
  end

endmodule

[src/bcs_back.sv]
// Back end: executes stack operations on the character store and
// holds the result register. Depends on bcs_pkg.
module bcs_back #(
  parameter int CAPACITY = bcs_pkg::CAPACITY_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  bcs_pkg::qhead_t head,
  output logic            take,
  output logic            res_valid,
  input  logic            res_ready,
  output bcs_pkg::res_t   res
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DONE,
    S_RF_RD,
    S_RF_USE,
    S_SO_START,
    S_SO_FIRST,
    S_SO_CMP,
    S_SO_LAST,
    S_RV_A,
    S_RV_B,
    S_RV_C,
    S_RV_D
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [7:0]      top_reg;
  logic [7:0]      popped;
  logic            pop_ok;
  logic [7:0]      carry;
  logic [7:0]      hold;
  logic [AW-1:0]   idx;
  logic [AW-1:0]   lim;
  logic [AW-1:0]   lo;
  logic [AW-1:0]   hi;

  logic [7:0]      mem [CAPACITY];
  logic [7:0]      rdata;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [7:0]      mem_wdata;
  logic [AW-1:0]   mem_raddr;

  logic [CW-1:0]   cnt_m1;
  logic            full;
  logic            empty;
  logic            top_match;
  logic            do_push;
  logic            slot_free;
  logic [AW:0]     gap;

  assign cnt_m1    = count - CW'(1);
  assign full      = (count == CW'(CAPACITY));
  assign empty     = (count == '0);
  assign top_match = !empty && (top_reg == head.item.ch);
  assign slot_free = !res_valid || res_ready;
  assign take      = (state == S_IDLE) && head.valid;
  assign gap       = {1'b0, hi} - {1'b0, lo};

  // a push happens when not full: for push, clear, and cancel without a match
  always_comb begin
    case (head.item.op)
      bcs_pkg::OP_PUSH:   do_push = !full;
      bcs_pkg::OP_CLEAR:  do_push = !full;
      bcs_pkg::OP_CANCEL: do_push = !full && !top_match;
      default:            do_push = 1'b0;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[AW-1:0];
    mem_wdata = head.item.ch;
    mem_raddr = cnt_m1[AW-1:0];
    case (state)
      S_IDLE:     mem_we = take && do_push;
      S_SO_START: mem_raddr = '0;
      S_SO_FIRST: mem_raddr = idx;
      S_SO_CMP: begin
        mem_we    = 1'b1;
        mem_waddr = idx - AW'(1);
        mem_wdata = (carry > rdata) ? rdata : carry;
        mem_raddr = idx + AW'(1);
      end
      S_SO_LAST: begin
        mem_we    = 1'b1;
        mem_waddr = lim;
        mem_wdata = carry;
      end
      S_RV_A:     mem_raddr = lo;
      S_RV_B:     mem_raddr = hi;
      S_RV_C: begin
        mem_we    = 1'b1;
        mem_waddr = lo;
        mem_wdata = rdata;
      end
      S_RV_D: begin
        mem_we    = 1'b1;
        mem_waddr = hi;
        mem_wdata = hold;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (take) begin
            popped <= bcs_pkg::EMPTY_MARK;
            pop_ok <= 1'b0;
            state  <= S_DONE;
            if (do_push) begin
              top_reg <= head.item.ch;
              count   <= count + CW'(1);
            end else begin
              case (head.item.op)
                bcs_pkg::OP_POP: begin
                  if (!empty) begin
                    popped <= top_reg;
                    pop_ok <= 1'b1;
                    count  <= cnt_m1;
                    if (cnt_m1 != '0) state <= S_RF_RD;
                  end
                end
                bcs_pkg::OP_CLEAR: begin
                  if (full) count <= '0;
                end
                bcs_pkg::OP_CANCEL: begin
                  if (top_match) begin
                    count <= cnt_m1;
                    if (cnt_m1 != '0) state <= S_RF_RD;
                  end
                end
                bcs_pkg::OP_SORT: begin
                  if (count > CW'(1)) begin
                    lim   <= cnt_m1[AW-1:0];
                    idx   <= AW'(1);
                    state <= S_SO_START;
                  end
                end
                bcs_pkg::OP_REVERSE: begin
                  if (count > CW'(1)) begin
                    lo    <= '0;
                    hi    <= cnt_m1[AW-1:0];
                    state <= S_RV_A;
                  end
                end
                default: state <= S_DONE;
              endcase
            end
          end
        end
        S_RF_RD:  state <= S_RF_USE;
        S_RF_USE: begin
          top_reg <= rdata;
          state   <= S_DONE;
        end
        S_SO_START: state <= S_SO_FIRST;
        S_SO_FIRST: begin
          carry <= rdata;
          state <= S_SO_CMP;
        end
        S_SO_CMP: begin
          if (!(carry > rdata)) carry <= rdata;
          if (idx == lim) begin
            state <= S_SO_LAST;
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_SO_LAST: begin
          if (lim == AW'(1)) begin
            state <= S_RF_RD;
          end else begin
            lim   <= lim - AW'(1);
            idx   <= AW'(1);
            state <= S_SO_START;
          end
        end
        S_RV_A: state <= S_RV_B;
        S_RV_B: begin
          hold  <= rdata;
          state <= S_RV_C;
        end
        S_RV_C: state <= S_RV_D;
        S_RV_D: begin
          lo <= lo + AW'(1);
          hi <= hi - AW'(1);
          if (gap > (AW+1)'(2)) state <= S_RV_A;
          else                  state <= S_RF_RD;
        end
        S_DONE: begin
          if (slot_free) begin
            res_valid       <= 1'b1;
            res.popped_char <= popped;
            res.pop_valid   <= pop_ok;
            res.top_char    <= empty ? bcs_pkg::EMPTY_MARK : top_reg;
            res.fill_count  <= 5'(count);
            res.is_empty    <= empty;
            res.is_full     <= full;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/bounded_char_stack_with_sort_unit.sv]
// Stack unit top: bcs_front queue feeding bcs_back; depends on bcs_pkg.
// Path of a word: the front queue, then the back end in idle, then any refill of
//   the top register (pop, cancel-pop) or sort/reverse passes, then the result
//   register, which waits while a result is still held. The back end takes no new
//   word until its result is registered; the sort's bubble passes take the longest.
// Reset (rst, synchronous) empties stack, queue and result; store not cleared.
module bounded_char_stack_with_sort_unit #(
  parameter int CAPACITY = bcs_pkg::CAPACITY_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  bcs_pkg::cmd_t cmd,
  output logic          res_valid,
  input  logic          res_ready,
  output bcs_pkg::res_t res
);

  // decoded command at the head of the queue, and the back end's pull
  bcs_pkg::qhead_t head;
  logic            take;

  // front: takes words while the back end is busy, up to the queue depth
  bcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .head      (head),
    .take      (take)
  );

  // back: store, sequencer for sort/reverse, and the result register
  bcs_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .take      (take),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

[src/bcs_checker.sv]
// Port-level checks on the result channel of the stack unit.
// Depends on bcs_pkg; bound to bounded_char_stack_with_sort_unit.
module bcs_checker (
  input logic          clk,
  input logic          rst,
  input logic          res_valid,
  input logic          res_ready,
  input bcs_pkg::res_t res
);

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.is_empty == (res.fill_count == 5'd0)))
    else $error("is_empty disagrees with fill_count");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.is_empty |-> res.top_char == bcs_pkg::EMPTY_MARK)
    else $error("empty stack must show mark as top");

  a_no_pop_mark: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.pop_valid |-> res.popped_char == bcs_pkg::EMPTY_MARK)
    else $error("popped char without a pop must be the mark");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("result dropped or changed while stalled");

endmodule

bind bounded_char_stack_with_sort_unit bcs_checker u_bcs_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

[tb/sv/bcs_stack_checker.sv]
// Checker for the bounded character stack: watches both channels, predicts
// each result word from its own stack copy and compares field by field.
// Depends on bcs_pkg for the word types, action codes and the empty mark.
module bcs_stack_checker #(
  parameter int CAPACITY = bcs_pkg::CAPACITY_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  logic          cmd_ready,
  input  bcs_pkg::cmd_t cmd,
  input  logic          res_valid,
  input  logic          res_ready,
  input  bcs_pkg::res_t res,
  output int            fail_count,
  output int            pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]    stack_chars [CAPACITY];
  int            stack_depth;
  bcs_pkg::res_t status_q [$];

  initial begin
    fail_count    = 0;
    pending_words = 0;
    stack_depth   = 0;
    foreach (stack_chars[i]) stack_chars[i] = 8'h00;
  end

  function automatic void store_char(logic [7:0] ch);
    if (stack_depth < CAPACITY) begin
      stack_chars[stack_depth] = ch;
      stack_depth++;
    end
  endfunction

  // apply one command word to the local stack, return the status word it gives
  function automatic bcs_pkg::res_t predict_stack_op(bcs_pkg::cmd_t w);
    bcs_pkg::res_t r;
    logic [7:0]    t;
    int            i;
    int            j;
    r.popped_char = bcs_pkg::EMPTY_MARK;
    r.pop_valid   = 1'b0;
    case (w.action)
      bcs_pkg::ACT_PUSH: store_char(w.push_char);
      bcs_pkg::ACT_POP: begin
        if (stack_depth > 0) begin
          stack_depth--;
          r.popped_char = stack_chars[stack_depth];
          r.pop_valid   = 1'b1;
        end
      end
      bcs_pkg::ACT_CLEAR: begin
        if (stack_depth >= CAPACITY) stack_depth = 0;
        else store_char(w.push_char);
      end
      bcs_pkg::ACT_CANCEL: begin
        // matching top is dropped silently, pop_valid stays low
        if (stack_depth > 0 && stack_chars[stack_depth-1] == w.push_char) stack_depth--;
        else store_char(w.push_char);
      end
      bcs_pkg::ACT_SORT: begin
        for (i = 0; i < stack_depth; i++) begin
          for (j = i + 1; j < stack_depth; j++) begin
            if (stack_chars[i] > stack_chars[j]) begin
              t = stack_chars[i];
              stack_chars[i] = stack_chars[j];
              stack_chars[j] = t;
            end
          end
        end
      end
      bcs_pkg::ACT_REVERSE: begin
        i = 0;
        j = stack_depth - 1;
        while (i < j) begin
          t = stack_chars[i];
          stack_chars[i] = stack_chars[j];
          stack_chars[j] = t;
          i++;
          j--;
        end
      end
      default: ;  // codes 6 and 7 only report status
    endcase
    r.top_char   = (stack_depth > 0) ? stack_chars[stack_depth-1] : bcs_pkg::EMPTY_MARK;
    r.fill_count = 5'(stack_depth);
    r.is_empty   = (stack_depth == 0);
    r.is_full    = (stack_depth >= CAPACITY);
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      $display("[%0t] %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    bcs_pkg::res_t want;
    if (rst) begin
      status_q.delete();
      stack_depth   = 0;
      pending_words = 0;
    end else begin
      if (cmd_valid && cmd_ready) status_q.push_back(predict_stack_op(cmd));
      if (res_valid && res_ready) begin
        if (status_q.size() == 0) begin
          fail_count++;
          $display("[%0t] unexpected result word: expected none, actual %h", $time, res);
        end else begin
          want = status_q.pop_front();
          check_field("popped_char", want.popped_char, res.popped_char);
          check_field("pop_valid", 8'(want.pop_valid), 8'(res.pop_valid));
          check_field("top_char", want.top_char, res.top_char);
          check_field("fill_count", 8'(want.fill_count), 8'(res.fill_count));
          check_field("is_empty", 8'(want.is_empty), 8'(res.is_empty));
          check_field("is_full", 8'(want.is_full), 8'(res.is_full));
        end
      end
      pending_words = status_q.size();
    end
  end

endmodule

[tb/sv/tb_bounded_char_stack_with_sort_unit.sv]
// Top of the stack testbench: clock, reset, command stimulus, result-side
// backpressure and the verdict. Needs bcs_pkg, the unit and bcs_stack_checker.
module tb_bounded_char_stack_with_sort_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // codes 6 and 7 have no name in the package; both are no-ops
  localparam logic [2:0] ACT_NOP_LO = 3'd6;
  localparam logic [2:0] ACT_NOP_HI = 3'd7;

  localparam int CAP         = bcs_pkg::CAPACITY_DEFAULT;
  localparam int BLOCKS      = 26;   // random part: BLOCKS x BLOCK_WORDS words
  localparam int BLOCK_WORDS = 50;
  localparam int HOLD_CYCLES = 400;  // long receiver hold, fills the queue
  localparam int DRAIN_WAIT  = 200;  // longer than the worst sort

  typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} mix_t;

  logic          clk;
  logic          rst;
  logic          cmd_valid;
  logic          cmd_ready;
  bcs_pkg::cmd_t cmd;
  logic          res_valid;
  logic          res_ready;
  bcs_pkg::res_t res;
  int            fail_count;
  int            pending_words;
  bit            tx_idle_on;
  bit            rx_idle_on;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  bounded_char_stack_with_sort_unit #(.CAPACITY(CAP)) DUT (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  bcs_stack_checker #(.CAPACITY(CAP)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .fail_count   (fail_count),
    .pending_words(pending_words)
  );

  function automatic bcs_pkg::cmd_t mk_word(logic [2:0] act, logic [7:0] ch);
    bcs_pkg::cmd_t w;
    w.action    = act;
    w.push_char = ch;
    return w;
  endfunction

  // Random command word. The mix picks the action weights so the stack
  // climbs to full, drains to empty, or wanders. A narrow alphabet makes
  // push-or-cancel hit a matching top often.
  function automatic bcs_pkg::cmd_t gen_word(mix_t mix, bit narrow);
    int         wt [7];
    int         r;
    int         k;
    logic [2:0] act;
    logic [7:0] ch;
    //                push pop clr cnc srt rev nop
    case (mix)
      MIX_FILL:  wt = '{45,  8, 15, 20,  5,  5,  2};
      MIX_DRAIN: wt = '{15, 45,  5, 20,  7,  6,  2};
      default:   wt = '{25, 25, 10, 20,  8,  8,  4};
    endcase
    r   = $urandom_range(99);
    act = ACT_NOP_LO;
    for (k = 0; k < 7; k++) begin
      if (r < wt[k]) begin
        act = 3'(k);
        break;
      end
      r -= wt[k];
    end
    if (act == ACT_NOP_LO && $urandom_range(1)) act = ACT_NOP_HI;
    ch = narrow ? 8'(8'h41 + $urandom_range(2)) : 8'($urandom_range(255));
    return mk_word(act, ch);
  endfunction

  // Offer one word and hold it until accepted. Entered and left at a falling
  // edge; valid stays high into the next call unless a gap is taken.
  task automatic send_word(bcs_pkg::cmd_t w);
    int gap;
    if (tx_idle_on && $urandom_range(99) < 20) begin
      cmd_valid = 1'b0;
      gap = $urandom_range(1, 3);
      repeat (gap) @(negedge clk);
    end
    cmd       = w;
    cmd_valid = 1'b1;
    do @(posedge clk); while (!cmd_ready);
    @(negedge clk);
  endtask

  // Result side: random ready, plus two long holds triggered by the word count
  // so the sender keeps offering while the unit backs up.
  initial begin
    int rx_seen;
    int hold_left;
    int last_hold_at;
    res_ready    = 1'b0;
    rx_seen      = 0;
    hold_left    = 0;
    last_hold_at = -1;
    forever begin
      @(posedge clk);
      if (res_valid && res_ready) rx_seen++;
      @(negedge clk);
      if ((rx_seen == 200 || rx_seen == 800) && last_hold_at != rx_seen) begin
        hold_left    = HOLD_CYCLES;
        last_hold_at = rx_seen;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ready = 1'b0;
      end else if (rx_idle_on && $urandom_range(99) < 30) begin
        res_ready = 1'b0;
      end else begin
        res_ready = 1'b1;
      end
    end
  end

  initial begin
    int   i;
    int   blk;
    mix_t mix;
    bit   narrow;
    rst        = 1'b1;
    cmd_valid  = 1'b0;
    cmd        = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // directed: empty-stack cases first
    send_word(mk_word(bcs_pkg::ACT_POP, 8'hFF));      // pop on empty gives the mark
    send_word(mk_word(bcs_pkg::ACT_CANCEL, 8'h00));   // cancel on empty pushes
    send_word(mk_word(bcs_pkg::ACT_CANCEL, 8'h00));   // matching top is removed
    send_word(mk_word(bcs_pkg::ACT_PUSH, 8'hFF));
    send_word(mk_word(bcs_pkg::ACT_SORT, 8'h00));     // one entry: no change
    send_word(mk_word(bcs_pkg::ACT_REVERSE, 8'h00));
    send_word(mk_word(ACT_NOP_LO, 8'h5A));
    // fill to capacity with falling bytes so sort has real work
    for (i = 0; i < CAP - 1; i++)
      send_word(mk_word(i[0] ? bcs_pkg::ACT_CLEAR : bcs_pkg::ACT_PUSH,
                        8'(8'hF0 - 8'(i * 16))));
    send_word(mk_word(bcs_pkg::ACT_PUSH, 8'h11));     // full: ignored
    send_word(mk_word(bcs_pkg::ACT_CANCEL, 8'h22));   // full, top differs: ignored
    send_word(mk_word(bcs_pkg::ACT_SORT, 8'h00));
    send_word(mk_word(bcs_pkg::ACT_REVERSE, 8'h00));
    send_word(mk_word(bcs_pkg::ACT_POP, 8'h00));
    send_word(mk_word(bcs_pkg::ACT_CLEAR, 8'h7F));    // not full: pushes
    send_word(mk_word(bcs_pkg::ACT_CLEAR, 8'h80));    // full: empties

    // random blocks; a run of blocks in the middle has no idling anywhere
    for (blk = 0; blk < BLOCKS; blk++) begin
      mix        = mix_t'($urandom_range(2));
      narrow     = 1'($urandom_range(1));
      tx_idle_on = !(blk >= 10 && blk < 14);
      rx_idle_on = tx_idle_on;
      for (i = 0; i < BLOCK_WORDS; i++) send_word(gen_word(mix, narrow));
    end
    cmd_valid  = 1'b0;
    rx_idle_on = 1'b1;

    while (pending_words != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog, far beyond a run of full-stack sorts with every stall taken
  initial begin
    #30_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
